// File: hw/rtl/ffa_pkg.sv
`timescale 1ns / 1ps

package ffa_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 64;
  localparam int unsigned ADDR_BITS_DEF  = 24;
  localparam int unsigned FIELD_W        = 24;
  localparam int unsigned HDR_W          = 7;
  localparam int unsigned HEAP_RST       = 1048576;
  localparam int unsigned HDR_RST        = 16;

  // configuration register indexes
  localparam logic CFG_HEAP_BYTES   = 1'b0;
  localparam logic CFG_HEADER_BYTES = 1'b1;

  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_RESIZE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NOSPACE = 2'd1,
    STS_NOTUSED = 2'd2,
    STS_KEPT    = 2'd3
  } sts_e;

  // entry table read address source
  typedef enum logic [1:0] {
    RS_NONE = 2'd0,
    RS_HEAD = 2'd1,
    RS_NEXT = 2'd2,
    RS_MA   = 2'd3
  } rd_sel_e;

  // entry table write operations
  typedef enum logic [2:0] {
    WR_NONE      = 3'd0,
    WR_INIT0     = 3'd1,
    WR_SPLIT_S   = 3'd2,
    WR_SPLIT_CUR = 3'd3,
    WR_TAKE      = 3'd4,
    WR_FREE      = 3'd5,
    WR_MERGE     = 3'd6,
    WR_PREVC     = 3'd7
  } wr_op_e;

  // spare slot stack operations
  typedef enum logic [1:0] {
    SP_NONE = 2'd0,
    SP_FILL = 2'd1,
    SP_POP  = 2'd2,
    SP_PUSH = 2'd3
  } sp_op_e;

  typedef enum logic [2:0] {
    RES_OK0     = 3'd0,
    RES_NOSPACE = 3'd1,
    RES_NOTUSED = 3'd2,
    RES_KEPT    = 3'd3,
    RES_GRANT   = 3'd4,
    RES_MOVED   = 3'd5
  } res_e;

  typedef struct packed {
    logic    ld_in;
    rd_sel_e rd_sel;
    logic    walk_clr;
    logic    walk_inc;
    logic    lat_cur;
    logic    lat_ri;
    logic    lat_a;
    logic    lat_c;
    logic    ma_ri;
    logic    ma_p;
    wr_op_e  wr_op;
    sp_op_e  sp_op;
    logic    sw_clr;
    logic    out_load;
    res_e    res_sel;
  } ffa_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic addr_zero;
    logic head_valid;
    logic nxt_valid;
    logic cnt_last;
    logic rd_used;
    logic fit_hit;
    logic find_hit;
    logic len_ge;
    logic split_ok;
    logic b_merge;
    logic a_prev_valid;
    logic sw_last;
  } ffa_stat_t;

endpackage

// File: hw/rtl/ffa_ram.sv
`timescale 1ns / 1ps

module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ffa_ctrl.sv
`timescale 1ns / 1ps

module ffa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ffa_pkg::ffa_cmd_t cmd_o,
  input  ffa_pkg::ffa_stat_t stat_i
);
  import ffa_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_DISP    = 16'h0002,
    S_INIT_W  = 16'h0004,
    S_INIT_SW = 16'h0008,
    S_WALK    = 16'h0010,
    S_CHK     = 16'h0020,
    S_FIT_DEC = 16'h0040,
    S_SPLIT_S = 16'h0080,
    S_SPLIT_C = 16'h0100,
    S_REL_CLR = 16'h0200,
    S_M_RD    = 16'h0400,
    S_M_A     = 16'h0800,
    S_M_B     = 16'h1000,
    S_M_PC    = 16'h2000,
    S_M_END   = 16'h4000,
    S_DONE    = 16'h8000
  } state_e;

  state_e   state_q, state_d;
  logic     fit_q, fit_d;        // walker looks for a fit, else for a used address
  logic     moving_q, moving_d;  // resize that moves: release old block after alloc
  logic     second_q, second_d;  // merging the previous neighbor
  res_e     res_q, res_d;
  logic     out_valid_q, out_valid_d;
  ffa_cmd_t cmd;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  always_comb begin
    state_d  = state_q;
    fit_d    = fit_q;
    moving_d = moving_q;
    second_d = second_q;
    res_d    = res_q;
    cmd      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.ld_in = 1'b1;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        moving_d = 1'b0;
        unique case (stat_i.cmd)
          CMD_INIT: state_d = S_INIT_W;
          CMD_ALLOC: begin
            fit_d   = 1'b1;
            state_d = S_WALK;
          end
          CMD_RELEASE: begin
            if (stat_i.addr_zero) begin
              res_d   = RES_OK0;
              state_d = S_DONE;
            end else begin
              fit_d   = 1'b0;
              state_d = S_WALK;
            end
          end
          CMD_RESIZE: begin
            fit_d   = stat_i.addr_zero;
            state_d = S_WALK;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_INIT_W: begin
        cmd.wr_op  = WR_INIT0;
        cmd.sw_clr = 1'b1;
        state_d    = S_INIT_SW;
      end
      S_INIT_SW: begin
        cmd.sp_op = SP_FILL;
        if (stat_i.sw_last) begin
          res_d   = RES_OK0;
          state_d = S_DONE;
        end
      end
      S_WALK: begin
        if (stat_i.head_valid) begin
          cmd.rd_sel   = RS_HEAD;
          cmd.walk_clr = 1'b1;
          state_d      = S_CHK;
        end else begin
          res_d   = fit_q ? RES_NOSPACE : RES_NOTUSED;
          state_d = S_DONE;
        end
      end
      S_CHK: begin
        if (fit_q && stat_i.fit_hit) begin
          cmd.lat_cur = 1'b1;
          state_d     = S_FIT_DEC;
        end else if (!fit_q && stat_i.find_hit) begin
          cmd.lat_ri = 1'b1;
          if (stat_i.cmd == CMD_RELEASE) begin
            state_d = S_REL_CLR;
          end else if (stat_i.len_ge) begin
            res_d   = RES_KEPT;
            state_d = S_DONE;
          end else begin
            fit_d    = 1'b1;
            moving_d = 1'b1;
            state_d  = S_WALK;
          end
        end else if (stat_i.nxt_valid && !stat_i.cnt_last) begin
          cmd.rd_sel   = RS_NEXT;
          cmd.walk_inc = 1'b1;
        end else begin
          res_d   = fit_q ? RES_NOSPACE : RES_NOTUSED;
          state_d = S_DONE;
        end
      end
      S_FIT_DEC: begin
        if (stat_i.split_ok) begin
          cmd.sp_op = SP_POP;
          state_d   = S_SPLIT_S;
        end else begin
          cmd.wr_op = WR_TAKE;
          res_d     = RES_GRANT;
          state_d   = moving_q ? S_REL_CLR : S_DONE;
        end
      end
      S_SPLIT_S: begin
        cmd.wr_op = WR_SPLIT_S;
        state_d   = S_SPLIT_C;
      end
      S_SPLIT_C: begin
        cmd.wr_op = WR_SPLIT_CUR;
        res_d     = RES_GRANT;
        state_d   = moving_q ? S_REL_CLR : S_DONE;
      end
      S_REL_CLR: begin
        cmd.wr_op = WR_FREE;
        cmd.ma_ri = 1'b1;
        second_d  = 1'b0;
        res_d     = moving_q ? RES_MOVED : RES_OK0;
        state_d   = S_M_RD;
      end
      S_M_RD: begin
        cmd.rd_sel = RS_MA;
        state_d    = S_M_A;
      end
      S_M_A: begin
        cmd.lat_a = 1'b1;
        if (!stat_i.rd_used && stat_i.nxt_valid) begin
          cmd.rd_sel = RS_NEXT;
          state_d    = S_M_B;
        end else begin
          state_d = S_M_END;
        end
      end
      S_M_B: begin
        if (stat_i.b_merge) begin
          cmd.wr_op = WR_MERGE;
          cmd.sp_op = SP_PUSH;
          cmd.lat_c = 1'b1;
          state_d   = stat_i.nxt_valid ? S_M_PC : S_M_END;
        end else begin
          state_d = S_M_END;
        end
      end
      S_M_PC: begin
        cmd.wr_op = WR_PREVC;
        state_d   = S_M_END;
      end
      S_M_END: begin
        if (!second_q && stat_i.a_prev_valid) begin
          cmd.ma_p = 1'b1;
          second_d = 1'b1;
          state_d  = S_M_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          cmd.res_sel  = res_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fit_q       <= 1'b0;
      moving_q    <= 1'b0;
      second_q    <= 1'b0;
      res_q       <= RES_OK0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fit_q       <= fit_d;
      moving_q    <= moving_d;
      second_q    <= second_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISP))
    else $error("accepted item did not reach dispatch");

  a_moving_resize: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (moving_q && state_q != S_IDLE && state_q != S_DISP) |-> (stat_i.cmd == CMD_RESIZE))
    else $error("moving flag outside a resize");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside done state");

endmodule

// File: hw/rtl/ffa_dp.sv
`timescale 1ns / 1ps

module ffa_dp #(
  parameter int unsigned MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned ADDR_BITS  = ffa_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [ffa_pkg::FIELD_W-1:0] cfg_data_i,
  input  logic [1:0]                  in_cmd_i,
  input  logic [ffa_pkg::FIELD_W-1:0] in_size_i,
  input  logic [ffa_pkg::FIELD_W-1:0] in_addr_i,
  output logic [1:0]                  out_status_o,
  output logic [ffa_pkg::FIELD_W-1:0] out_addr_o,
  output logic [ffa_pkg::FIELD_W-1:0] out_copy_o,
  input  ffa_pkg::ffa_cmd_t           cmd_i,
  output ffa_pkg::ffa_stat_t          stat_o
);
  import ffa_pkg::*;

  localparam int unsigned AW   = ADDR_BITS;
  localparam int unsigned SW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned IW   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CW   = (AW > FIELD_W) ? AW : FIELD_W;
  localparam int unsigned SUMW = CW + 1;
  localparam logic [IW-1:0] END_MARK = IW'(MAX_BLOCKS);

  // configuration
  logic [FIELD_W-1:0] heap_q;
  logic [HDR_W-1:0]   hdr_q;

  // latched request
  cmd_e               cmd_q;
  logic [FIELD_W-1:0] size_q;
  logic [FIELD_W-1:0] addr_q;

  // list and walker state
  logic [IW-1:0] head_q;
  logic [SW-1:0] cnt_q;
  logic [SW-1:0] rd_idx_q;
  logic [SW-1:0] cur_idx_q;
  logic [AW-1:0] cur_off_q;
  logic [AW-1:0] cur_len_q;
  logic [IW-1:0] cur_next_q;
  logic [SW-1:0] ri_q;
  logic [AW-1:0] old_len_q;
  logic [SW-1:0] ma_q;
  logic [SW-1:0] a_idx_q;
  logic [AW-1:0] a_off_q;
  logic [AW-1:0] a_len_q;
  logic [IW-1:0] a_prev_q;
  logic [IW-1:0] c_q;
  logic [SW-1:0] s_q;
  logic [SW-1:0] sw_q;
  logic [IW-1:0] spare_cnt_q;
  logic [IW-1:0] spare_cnt_d;

  logic [1:0]         out_status_q;
  logic [FIELD_W-1:0] out_addr_q;
  logic [FIELD_W-1:0] out_copy_q;

  // table ports
  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic [AW-1:0] rd_off, rd_len;
  logic          rd_used;
  logic [IW-1:0] rd_next, rd_prev;

  logic          off_we, len_we, used_we, next_we, prev_we;
  logic [SW-1:0] off_wa, len_wa, used_wa, next_wa, prev_wa;
  logic [AW-1:0] off_wd, len_wd;
  logic          used_wd;
  logic [IW-1:0] next_wd, prev_wd;

  logic          sp_we, sp_re;
  logic [SW-1:0] sp_wa, sp_ra, sp_wd, sp_rd;

  // arithmetic
  logic [AW-1:0] two_h;
  logic [8:0]    three_h;
  logic [AW-1:0] len0;
  logic [AW-1:0] a_end;
  logic [AW-1:0] merge_len;
  logic [AW-1:0] split_off;
  logic [AW-1:0] split_len;

  assign two_h     = AW'({hdr_q, 1'b0});
  assign three_h   = 9'({hdr_q, 1'b0}) + 9'(hdr_q);
  assign len0      = (heap_q > FIELD_W'(three_h)) ? AW'(heap_q - FIELD_W'(three_h)) : '0;
  assign a_end     = a_off_q + a_len_q + AW'(hdr_q);
  assign merge_len = a_len_q + rd_len + AW'(hdr_q);
  assign split_off = cur_off_q + AW'(size_q) + AW'(hdr_q);
  assign split_len = cur_len_q - AW'(size_q) - AW'(hdr_q);

  // read address
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = ma_q;
    unique case (cmd_i.rd_sel)
      RS_HEAD: rd_addr = SW'(head_q);
      RS_NEXT: rd_addr = SW'(rd_next);
      RS_MA:   rd_addr = ma_q;
      RS_NONE: rd_en   = 1'b0;
      default: rd_en   = 1'b0;
    endcase
  end

  // table writes
  always_comb begin
    off_we  = 1'b0; off_wa  = '0; off_wd  = '0;
    len_we  = 1'b0; len_wa  = '0; len_wd  = '0;
    used_we = 1'b0; used_wa = '0; used_wd = 1'b0;
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    unique case (cmd_i.wr_op)
      WR_INIT0: begin
        off_we  = 1'b1; off_wd = two_h;
        len_we  = 1'b1; len_wd = len0;
        used_we = 1'b1;
        next_we = 1'b1; next_wd = END_MARK;
        prev_we = 1'b1; prev_wd = END_MARK;
      end
      WR_SPLIT_S: begin
        off_we  = 1'b1; off_wa  = sp_rd; off_wd = split_off;
        len_we  = 1'b1; len_wa  = sp_rd; len_wd = split_len;
        used_we = 1'b1; used_wa = sp_rd;
        next_we = 1'b1; next_wa = sp_rd; next_wd = cur_next_q;
        prev_we = 1'b1; prev_wa = sp_rd; prev_wd = IW'(cur_idx_q);
      end
      WR_SPLIT_CUR: begin
        prev_we = (cur_next_q < END_MARK);
        prev_wa = SW'(cur_next_q);
        prev_wd = IW'(s_q);
        next_we = 1'b1; next_wa = cur_idx_q; next_wd = IW'(s_q);
        len_we  = 1'b1; len_wa  = cur_idx_q; len_wd  = AW'(size_q);
        used_we = 1'b1; used_wa = cur_idx_q; used_wd = 1'b1;
      end
      WR_TAKE: begin
        used_we = 1'b1; used_wa = cur_idx_q; used_wd = 1'b1;
      end
      WR_FREE: begin
        used_we = 1'b1; used_wa = ri_q;
      end
      WR_MERGE: begin
        len_we  = 1'b1; len_wa  = a_idx_q; len_wd  = merge_len;
        next_we = 1'b1; next_wa = a_idx_q; next_wd = rd_next;
      end
      WR_PREVC: begin
        prev_we = 1'b1; prev_wa = SW'(c_q); prev_wd = IW'(a_idx_q);
      end
      WR_NONE: ;
      default: ;
    endcase
  end

  // spare slot stack
  always_comb begin
    sp_we       = 1'b0;
    sp_re       = 1'b0;
    sp_wa       = sw_q;
    sp_wd       = SW'(MAX_BLOCKS - 1) - sw_q;
    sp_ra       = SW'(spare_cnt_q - IW'(1));
    spare_cnt_d = spare_cnt_q;
    unique case (cmd_i.sp_op)
      SP_FILL: begin
        sp_we = 1'b1;
        if (stat_o.sw_last) begin
          spare_cnt_d = IW'(MAX_BLOCKS - 1);
        end
      end
      SP_POP: begin
        sp_re       = 1'b1;
        spare_cnt_d = spare_cnt_q - IW'(1);
      end
      SP_PUSH: begin
        if (spare_cnt_q < IW'(MAX_BLOCKS)) begin
          sp_we       = 1'b1;
          sp_wa       = SW'(spare_cnt_q);
          sp_wd       = rd_idx_q;
          spare_cnt_d = spare_cnt_q + IW'(1);
        end
      end
      SP_NONE: ;
      default: ;
    endcase
  end

  ffa_ram #(.WIDTH(AW), .DEPTH(MAX_BLOCKS)) u_off_ram (
    .clk_i, .we_i(off_we), .waddr_i(off_wa), .wdata_i(off_wd),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(rd_off)
  );
  ffa_ram #(.WIDTH(AW), .DEPTH(MAX_BLOCKS)) u_len_ram (
    .clk_i, .we_i(len_we), .waddr_i(len_wa), .wdata_i(len_wd),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(rd_len)
  );
  ffa_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_used_ram (
    .clk_i, .we_i(used_we), .waddr_i(used_wa), .wdata_i(used_wd),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(rd_used)
  );
  ffa_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(rd_next)
  );
  ffa_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_prev_ram (
    .clk_i, .we_i(prev_we), .waddr_i(prev_wa), .wdata_i(prev_wd),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(rd_prev)
  );
  ffa_ram #(.WIDTH(SW), .DEPTH(MAX_BLOCKS)) u_spare_ram (
    .clk_i, .we_i(sp_we), .waddr_i(sp_wa), .wdata_i(sp_wd),
    .re_i(sp_re), .raddr_i(sp_ra), .rdata_o(sp_rd)
  );

  // status toward the controller
  always_comb begin
    stat_o.cmd          = cmd_q;
    stat_o.addr_zero    = (addr_q == '0);
    stat_o.head_valid   = (head_q < END_MARK);
    stat_o.nxt_valid    = (rd_next < END_MARK);
    stat_o.cnt_last     = (cnt_q == SW'(MAX_BLOCKS - 1));
    stat_o.rd_used      = rd_used;
    stat_o.len_ge       = (CW'(rd_len) >= CW'(size_q));
    stat_o.fit_hit      = !rd_used && stat_o.len_ge;
    stat_o.find_hit     = rd_used && (CW'(rd_off) == CW'(addr_q));
    stat_o.split_ok     = (SUMW'(cur_len_q) > (SUMW'(size_q) + SUMW'(hdr_q)))
                          && (spare_cnt_q != '0);
    stat_o.b_merge      = !rd_used && (a_end == rd_off);
    stat_o.a_prev_valid = (a_prev_q < END_MARK);
    stat_o.sw_last      = (sw_q == SW'(MAX_BLOCKS - 2));
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q      <= FIELD_W'(HEAP_RST);
      hdr_q       <= HDR_W'(HDR_RST);
      head_q      <= END_MARK;
      spare_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_HEAP_BYTES:   heap_q <= cfg_data_i;
          CFG_HEADER_BYTES: hdr_q  <= cfg_data_i[HDR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.wr_op == WR_INIT0) begin
        head_q <= '0;
      end
      spare_cnt_q <= spare_cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      cmd_q  <= cmd_e'(in_cmd_i);
      size_q <= in_size_i;
      addr_q <= in_addr_i;
    end
    if (rd_en) begin
      rd_idx_q <= rd_addr;
    end
    if (cmd_i.walk_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.walk_inc) begin
      cnt_q <= cnt_q + SW'(1);
    end
    if (cmd_i.sw_clr) begin
      sw_q <= '0;
    end else if (cmd_i.sp_op == SP_FILL) begin
      sw_q <= sw_q + SW'(1);
    end
    if (cmd_i.lat_cur) begin
      cur_idx_q  <= rd_idx_q;
      cur_off_q  <= rd_off;
      cur_len_q  <= rd_len;
      cur_next_q <= rd_next;
    end
    if (cmd_i.lat_ri) begin
      ri_q      <= rd_idx_q;
      old_len_q <= rd_len;
    end
    if (cmd_i.ma_ri) begin
      ma_q <= ri_q;
    end else if (cmd_i.ma_p) begin
      ma_q <= SW'(a_prev_q);
    end
    if (cmd_i.lat_a) begin
      a_idx_q  <= rd_idx_q;
      a_off_q  <= rd_off;
      a_len_q  <= rd_len;
      a_prev_q <= rd_prev;
    end
    if (cmd_i.lat_c) begin
      c_q <= rd_next;
    end
    if (cmd_i.wr_op == WR_SPLIT_S) begin
      s_q <= sp_rd;
    end
    if (cmd_i.out_load) begin
      out_status_q <= STS_OK;
      out_addr_q   <= '0;
      out_copy_q   <= '0;
      unique case (cmd_i.res_sel)
        RES_NOSPACE: out_status_q <= STS_NOSPACE;
        RES_NOTUSED: out_status_q <= STS_NOTUSED;
        RES_KEPT: begin
          out_status_q <= STS_KEPT;
          out_addr_q   <= addr_q;
        end
        RES_GRANT: out_addr_q <= FIELD_W'(cur_off_q);
        RES_MOVED: begin
          out_addr_q <= FIELD_W'(cur_off_q);
          out_copy_q <= FIELD_W'(old_len_q);
        end
        RES_OK0: ;
        default: ;
      endcase
    end
  end

  assign out_status_o = out_status_q;
  assign out_addr_o   = out_addr_q;
  assign out_copy_o   = out_copy_q;

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sp_op == SP_POP) |-> (spare_cnt_q != '0))
    else $error("spare stack popped while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_cnt_q <= IW'(MAX_BLOCKS))
    else $error("spare count above table size");

  a_split_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_op == WR_SPLIT_CUR) |-> $past(cmd_i.wr_op == WR_SPLIT_S))
    else $error("split link update without new entry write");

endmodule

// File: hw/rtl/first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// s_axis    in         tvalid/tready         tuser: command; tdata: size, address
// m_axis    out        tvalid/tready         tuser: status; tdata: result_address, copy_bytes
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One item at a time. Init fills the spare slot stack. Allocate walks the block list
// one entry per cycle. Release: lookup walk plus merge; moving resize: lookup walk,
// fit walk and merge. Walk speed is set by the registered read of the block table.
// A result waits in the output register while the next item is taken; a new result
// waits until the previous one is taken. Reset empties the list; table memories hold
// nothing valid until init.

module first_fit_heap_allocator_top #(
  parameter int unsigned MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned ADDR_BITS  = ffa_pkg::ADDR_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [47:0]                 s_axis_tdata,  // size[23:0], address[47:24]
  input  logic [1:0]                  s_axis_tuser,  // command
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata,  // result_address[23:0], copy_bytes[47:24]
  output logic [1:0]                  m_axis_tuser,  // status
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [ffa_pkg::FIELD_W-1:0] cfg_data_i
);
  import ffa_pkg::*;

  ffa_cmd_t           cmd;
  ffa_stat_t          stat;
  logic [FIELD_W-1:0] out_addr;
  logic [FIELD_W-1:0] out_copy;

  assign cfg_ready_o = 1'b1;

  ffa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  ffa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (s_axis_tuser),
    .in_size_i    (s_axis_tdata[23:0]),
    .in_addr_i    (s_axis_tdata[47:24]),
    .out_status_o (m_axis_tuser),
    .out_addr_o   (out_addr),
    .out_copy_o   (out_copy),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

  assign m_axis_tdata = {out_copy, out_addr};

endmodule
